// ===== src/selective_repeat_send_window_defines.svh =====
// Assertion macros shared by the send-window checker.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRSW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("send window check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRSW_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("send window check failed");

`endif

// ===== src/srsw_pkg.sv =====
// Shared constants and types of the selective-repeat send window.
`timescale 1ns / 1ps
package srsw_pkg;

    localparam int MAX_PACKETS = 16384;
    localparam int IDX_W       = $clog2(MAX_PACKETS);
    localparam int MAX_WINDOW  = 16;
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W       = 15;
    localparam int WIN_W       = 5;
    localparam int TMO_W       = 10;
    localparam int SEQ_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [TMO_W-1:0] TIMER_MAX = '1;

    // Packet status codes.
    localparam logic [1:0] ST_UNSENT = 2'd0;
    localparam logic [1:0] ST_FLIGHT = 2'd1;
    localparam logic [1:0] ST_ACKED  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    // Register reset values.
    localparam logic [CNT_W-1:0] COUNT_RST   = 15'd1;
    localparam logic [WIN_W-1:0] WINDOW_RST  = 5'd10;
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 10'd50;

    // Operation codes.
    localparam logic OP_ACK  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Write request into the status memory.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [1:0]       data;
    } stat_wr_t;

endpackage

// ===== src/srsw_status_ram.sv =====
// Packet status memory: one write port, one registered read port.
`timescale 1ns / 1ps
module srsw_status_ram (
    input  logic                     aclk,
    input  srsw_pkg::stat_wr_t       wr,
    input  logic [srsw_pkg::IDX_W-1:0] rd_addr,
    output logic [1:0]               rd_data
);

    logic [1:0] mem [srsw_pkg::MAX_PACKETS];
    logic [1:0] rd_data_reg;

    // Write and read-before-write, both on the clock edge.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/selective_repeat_send_window.sv =====
// Top level of the selective-repeat send window.
//
//  Channel  Direction  Ports                       Beat
//  s_       in         s_op, s_ack_seq             one ack or one tick
//  m_       out        m_send_valid .. m_transfer_done  one result per input beat
//  cfg_     in         cfg_we, cfg_index, cfg_data register write, no wait
//
// After reset a clearing pass writes every status entry while s_ready stays
// low. A good ack writes its status, then does one memory read and one check
// per base position, sliding the base while entries are acked; a bad ack, or
// a tick once the transfer is done, goes straight to the final step. A tick
// walks the window through the one read port, then decides. Results wait in
// the output register; a stalled m_ in the final step holds the sequencer.
`timescale 1ns / 1ps
module selective_repeat_send_window (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [srsw_pkg::SEQ_W-1:0]        s_ack_seq,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_send_valid,
    output logic [srsw_pkg::IDX_W-1:0]        m_send_seq,
    output logic                              m_is_retransmit,
    output logic [srsw_pkg::IDX_W-1:0]        m_window_base,
    output logic [srsw_pkg::IDX_W-1:0]        m_window_top,
    output logic                              m_bad_ack,
    output logic                              m_transfer_done,
    input  logic                              cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW = srsw_pkg::IDX_W;
    localparam int SW = srsw_pkg::SLOT_W;
    localparam int TW = srsw_pkg::TMO_W;
    localparam int CW = srsw_pkg::CNT_W;
    localparam int WW = srsw_pkg::WIN_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCHK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DEC  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [WW-1:0] window_reg;
    logic [TW-1:0] timeout_reg;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [IW-1:0] base_reg, base_next;
    logic [IW-1:0] top_reg, top_next;
    logic          done_reg, done_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [WW-1:0] left_reg, left_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          rcand_reg, rcand_next;
    logic [IW-1:0] rcand_idx_reg, rcand_idx_next;
    logic          ucand_reg, ucand_next;
    logic [IW-1:0] ucand_idx_reg, ucand_idx_next;
    logic          res_sv_reg, res_sv_next;
    logic [IW-1:0] res_seq_reg, res_seq_next;
    logic          res_rt_reg, res_rt_next;
    logic          res_bad_reg, res_bad_next;
    logic [TW-1:0] timer_reg [srsw_pkg::MAX_WINDOW];
    logic          tmr_we;
    logic [SW-1:0] tmr_slot;
    logic [TW-1:0] tmr_data;
    logic          mv_reg, mv_next;
    logic          o_sv_reg, o_rt_reg, o_bad_reg, o_done_reg;
    logic [IW-1:0] o_seq_reg, o_base_reg, o_top_reg;
    logic          out_load;

    srsw_pkg::stat_wr_t wr;
    logic [IW-1:0] rd_addr;
    logic [1:0]    rd_data;

    logic [CW-1:0] cnt_eff;
    logic [IW-1:0] last_idx;
    logic [WW-1:0] win_eff;
    logic [TW-1:0] tmo_eff;
    logic [IW-1:0] base_clamp;
    logic [IW-1:0] top_clamp;
    logic [TW-1:0] cur_tmr;
    logic [TW-1:0] aged_tmr;

    // Top of the window for a given base.
    function automatic logic [IW-1:0] win_top(input logic [IW-1:0] b,
                                              input logic [WW-1:0] w,
                                              input logic [IW-1:0] last);
        logic [IW:0] t;
        t = {1'b0, b} + {{(IW+1-WW){1'b0}}, w} - {{IW{1'b0}}, 1'b1};
        win_top = (t > {1'b0, last}) ? last : t[IW-1:0];
    endfunction

    srsw_status_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Effective register values.
    always_comb begin
        cnt_eff = count_reg;
        if (count_reg == '0) cnt_eff = CW'(1);
        if (count_reg > CW'(srsw_pkg::MAX_PACKETS)) cnt_eff = CW'(srsw_pkg::MAX_PACKETS);
        last_idx = IW'(cnt_eff - CW'(1));
        win_eff = window_reg;
        if (window_reg == '0) win_eff = WW'(1);
        if (window_reg > WW'(srsw_pkg::MAX_WINDOW)) win_eff = WW'(srsw_pkg::MAX_WINDOW);
        tmo_eff = (timeout_reg == '0) ? TW'(1) : timeout_reg;
        base_clamp = (base_reg > last_idx) ? last_idx : base_reg;
        top_clamp = win_top(base_clamp, win_eff, last_idx);
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign cur_tmr  = timer_reg[pend_idx_reg[SW-1:0]];
    assign aged_tmr = (cur_tmr < srsw_pkg::TIMER_MAX) ? cur_tmr + TW'(1) : cur_tmr;
    assign out_load = (state_reg == S_FIN) && (!mv_reg || m_ready);

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        base_next      = base_reg;
        top_next       = top_reg;
        done_next      = done_reg;
        rd_idx_next    = rd_idx_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        rcand_next     = rcand_reg;
        rcand_idx_next = rcand_idx_reg;
        ucand_next     = ucand_reg;
        ucand_idx_next = ucand_idx_reg;
        res_sv_next    = res_sv_reg;
        res_seq_next   = res_seq_reg;
        res_rt_next    = res_rt_reg;
        res_bad_next   = res_bad_reg;
        wr             = '0;
        rd_addr        = base_reg;
        tmr_we         = 1'b0;
        tmr_slot       = pend_idx_reg[SW-1:0];
        tmr_data       = aged_tmr;
        case (state_reg)
            S_CLR: begin
                wr.en   = 1'b1;
                wr.addr = clr_idx_reg;
                wr.data = srsw_pkg::ST_UNSENT;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == '1) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    base_next    = base_clamp;
                    top_next     = top_clamp;
                    res_sv_next  = 1'b0;
                    res_seq_next = '0;
                    res_rt_next  = 1'b0;
                    res_bad_next = 1'b0;
                    rcand_next   = 1'b0;
                    ucand_next   = 1'b0;
                    if (s_op == srsw_pkg::OP_ACK) begin
                        if (s_ack_seq >= {{(srsw_pkg::SEQ_W-CW){1'b0}}, cnt_eff}) begin
                            res_bad_next = 1'b1;
                            state_next   = S_FIN;
                        end else begin
                            wr.en   = 1'b1;
                            wr.addr = s_ack_seq[IW-1:0];
                            wr.data = srsw_pkg::ST_ACKED;
                            state_next = S_SRD;
                        end
                    end else if (done_reg) begin
                        state_next = S_FIN;
                    end else begin
                        rd_idx_next = base_clamp;
                        left_next   = WW'(top_clamp - base_clamp) + WW'(1);
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SRD: begin
                rd_addr    = base_reg;
                state_next = S_SCHK;
            end
            S_SCHK: begin
                if (done_reg || rd_data != srsw_pkg::ST_ACKED) begin
                    state_next = S_FIN;
                end else if (base_reg >= last_idx) begin
                    done_next  = 1'b1;
                    state_next = S_FIN;
                end else begin
                    base_next  = base_reg + IW'(1);
                    state_next = S_SRD;
                end
            end
            S_SCAN: begin
                // Issue the next read while the previous entry is judged.
                rd_addr = rd_idx_reg;
                if (left_reg != '0) begin
                    rd_idx_next   = rd_idx_reg + IW'(1);
                    left_next     = left_reg - WW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                if (pend_reg) begin
                    if (rd_data == srsw_pkg::ST_FLIGHT) begin
                        tmr_we = 1'b1;
                        if (!rcand_reg && aged_tmr >= tmo_eff) begin
                            rcand_next     = 1'b1;
                            rcand_idx_next = pend_idx_reg;
                        end
                    end
                    if (!ucand_reg && rd_data == srsw_pkg::ST_UNSENT) begin
                        ucand_next     = 1'b1;
                        ucand_idx_next = pend_idx_reg;
                    end
                end
                if (left_reg == '0 && !pend_reg) state_next = S_DEC;
            end
            S_DEC: begin
                tmr_data = '0;
                if (rcand_reg) begin
                    tmr_we       = 1'b1;
                    tmr_slot     = rcand_idx_reg[SW-1:0];
                    res_sv_next  = 1'b1;
                    res_rt_next  = 1'b1;
                    res_seq_next = rcand_idx_reg;
                end else if (ucand_reg) begin
                    tmr_we       = 1'b1;
                    tmr_slot     = ucand_idx_reg[SW-1:0];
                    wr.en        = 1'b1;
                    wr.addr      = ucand_idx_reg;
                    wr.data      = srsw_pkg::ST_FLIGHT;
                    res_sv_next  = 1'b1;
                    res_seq_next = ucand_idx_reg;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_idx_reg <= '0;
            base_reg    <= '0;
            top_reg     <= '0;
            done_reg    <= 1'b0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            rcand_reg   <= 1'b0;
            ucand_reg   <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            base_reg    <= base_next;
            top_reg     <= top_next;
            done_reg    <= done_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            rcand_reg   <= rcand_next;
            ucand_reg   <= ucand_next;
            mv_reg      <= mv_next;
        end
    end

    // Payload registers of the sequencer.
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        pend_idx_reg  <= pend_idx_next;
        rcand_idx_reg <= rcand_idx_next;
        ucand_idx_reg <= ucand_idx_next;
        res_sv_reg    <= res_sv_next;
        res_seq_reg   <= res_seq_next;
        res_rt_reg    <= res_rt_next;
        res_bad_reg   <= res_bad_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= srsw_pkg::COUNT_RST;
            window_reg  <= srsw_pkg::WINDOW_RST;
            timeout_reg <= srsw_pkg::TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                srsw_pkg::REG_COUNT:   count_reg   <= cfg_data;
                srsw_pkg::REG_WINDOW:  window_reg  <= cfg_data[WW-1:0];
                srsw_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Retransmission timers, one per window slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < srsw_pkg::MAX_WINDOW; i++) timer_reg[i] <= '0;
        end else if (tmr_we) begin
            timer_reg[tmr_slot] <= tmr_data;
        end
    end

    // Output register: a result waits here for the m_ beat.
    always_comb begin
        mv_next = mv_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        if (out_load) mv_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_sv_reg   <= res_sv_reg;
            o_seq_reg  <= res_seq_reg;
            o_rt_reg   <= res_rt_reg;
            o_bad_reg  <= res_bad_reg;
            o_base_reg <= base_reg;
            o_top_reg  <= win_top(base_reg, win_eff, last_idx);
            o_done_reg <= done_reg;
        end
    end

    assign m_valid         = mv_reg;
    assign m_send_valid    = o_sv_reg;
    assign m_send_seq      = o_seq_reg;
    assign m_is_retransmit = o_rt_reg;
    assign m_window_base   = o_base_reg;
    assign m_window_top    = o_top_reg;
    assign m_bad_ack       = o_bad_reg;
    assign m_transfer_done = o_done_reg;

endmodule

// ===== src/srsw_checker.sv =====
// Port-level checks of the send window, bound to the top level.
`timescale 1ns / 1ps
`include "selective_repeat_send_window_defines.svh"
module srsw_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_send_valid,
    input logic [srsw_pkg::IDX_W-1:0] m_send_seq,
    input logic                       m_is_retransmit,
    input logic [srsw_pkg::IDX_W-1:0] m_window_base,
    input logic [srsw_pkg::IDX_W-1:0] m_window_top,
    input logic                       m_bad_ack,
    input logic                       m_transfer_done
);

    // A result that is not taken stays put.
    `SRSW_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_send_seq))
    // No send means the sequence and retransmit flag read zero.
    `SRSW_ASSERT_IMP(a_nosend, aclk, aresetn, m_valid && !m_send_valid, m_send_seq == '0 && !m_is_retransmit)
    // A rejected ack or a finished transfer never sends.
    `SRSW_ASSERT_IMP(a_badack, aclk, aresetn, m_valid && (m_bad_ack || m_transfer_done), !m_send_valid)
    // A send always lies inside the window.
    `SRSW_ASSERT_IMP(a_inwin, aclk, aresetn, m_valid && m_send_valid, m_send_seq >= m_window_base && m_send_seq <= m_window_top)

endmodule

bind selective_repeat_send_window srsw_checker u_srsw_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_send_valid    (m_send_valid),
    .m_send_seq      (m_send_seq),
    .m_is_retransmit (m_is_retransmit),
    .m_window_base   (m_window_base),
    .m_window_top    (m_window_top),
    .m_bad_ack       (m_bad_ack),
    .m_transfer_done (m_transfer_done)
);
